@@ rtl/core/sha1_pkg.sv @@
// Package: types and constants for the SHA-1 message hasher.
`timescale 1ns / 1ps
package sha1_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  function automatic logic [31:0] iv(input logic [2:0] i);
    case (i)
      3'd0: iv = IV0;
      3'd1: iv = IV1;
      3'd2: iv = IV2;
      3'd3: iv = IV3;
      default: iv = IV4;
    endcase
  endfunction

endpackage

@@ rtl/core/sha1_message_hasher.sv @@
// Top level: byte-serial SHA-1 hasher with a 16-word schedule memory.
`timescale 1ns / 1ps
// One byte at most is taken per item; a byte takes a read of the schedule word,
// then a merge and write back. Each 64th byte starts a compression: a prefetch
// step, then 80 rounds with one schedule memory read per cycle and one write in
// each round from 16 on, then a step that adds the round state into the chaining
// value. A last item adds padding, one byte at a time, plus one or two compressions,
// then gives the five digest words, h0 first, one per cycle while not stalled.
// Input stall is high whenever the block is busy.
module sha1_message_hasher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha1_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha1_pkg::out_item_t  out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUT  = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_PRE  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state;
  logic [31:0] wmem [16];
  logic [31:0] rd;
  logic [3:0]  raddr;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic [31:0] cv [5];
  logic [31:0] a, b, c, d, e;
  logic [63:0] bit_length;
  logic [5:0]  pos;
  logic [7:0]  cur_byte;
  logic        padding;
  logic        pad_mark;
  logic        pad_len;
  logic [3:0]  len_idx;
  logic [6:0]  rnd;
  logic [2:0]  widx;
  logic [31:0] x0, x1, x2;

  // byte merge
  logic [31:0] merged;
  always_comb begin
    merged = (pos[1:0] == 2'd0) ? 32'd0 : rd;
    unique case (pos[1:0])
      2'd0: merged[31:24] = cur_byte;
      2'd1: merged[23:16] = cur_byte;
      2'd2: merged[15:8]  = cur_byte;
      default: merged[7:0] = cur_byte;
    endcase
  end

  // rounds: schedule from four words; three come from the window registers
  logic [31:0] w, f, k, tmp;
  always_comb begin
    if (rnd < 7'd16) w = rd;
    else begin
      w = x0 ^ x1 ^ x2 ^ rd;
      w = {w[30:0], w[31]};
    end
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = sha1_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = sha1_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d; k = sha1_pkg::K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + w;
  end

  // A round needs words t-3,t-8,t-14,t-16. A single read port per cycle is used by
  // keeping a 16-entry shadow of recent words in the window registers below.
  logic [31:0] win [16];
  always_comb begin
    x0 = win[4'(rnd + 7'd13)];
    x1 = win[4'(rnd + 7'd8)];
    x2 = win[4'(rnd + 7'd2)];
  end

  always_comb begin
    raddr = 4'(rnd);
    if (state == S_IDLE || state == S_PAD) raddr = pos[5:2];
    if (state == S_PRE) raddr = 4'd0;
    if (state == S_RND) raddr = 4'(rnd + 7'd1);
  end

  always_ff @(posedge clk) begin
    rd <= wmem[raddr];
    if (we) wmem[waddr] <= wdata;
  end

  always_comb begin
    we = 1'b0; waddr = pos[5:2]; wdata = merged;
    if (state == S_PUT) we = 1'b1;
    if (state == S_RND && rnd >= 7'd16) begin
      we = 1'b1; waddr = 4'(rnd); wdata = w;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data.digest_word = cv[widx];
  assign out_data.word_index = widx;
  assign out_data.last_word = (widx == 3'd4);

  // next padding byte: 0x80 once, zeros, then the length big-endian
  logic [7:0] pad_byte;
  always_comb begin
    if (!pad_mark) pad_byte = sha1_pkg::PAD_BYTE;
    else if (!pad_len) pad_byte = 8'd0;
    else pad_byte = 8'(bit_length >> (7'd56 - {len_idx[2:0], 3'd0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bit_length <= '0;
      pos <= '0;
      padding <= 1'b0;
      pad_mark <= 1'b0;
      pad_len <= 1'b0;
      len_idx <= '0;
      rnd <= '0;
      widx <= '0;
      for (int i = 0; i < 5; i++) cv[i] <= sha1_pkg::iv(3'(i));
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          cur_byte <= in_data.msg_byte;
          padding <= in_data.last;
          pad_mark <= 1'b0;
          pad_len <= 1'b0;
          len_idx <= '0;
          if (in_data.has_byte) begin
            bit_length <= bit_length + 64'd8;
            state <= S_PUT;
          end else if (in_data.last) begin
            cur_byte <= sha1_pkg::PAD_BYTE;
            padding <= 1'b1;
            state <= S_PAD;
          end
        end
        S_PAD: begin
          cur_byte <= pad_byte;
          pad_mark <= 1'b1;
          state <= S_PUT;
        end
        S_PUT: begin
          pos <= pos + 6'd1;
          if (pad_mark) begin
            if (pad_len) len_idx <= len_idx + 4'd1;
            else if (pos + 6'd1 == 6'd56) pad_len <= 1'b1;
          end
          if (pos == 6'd63) begin
            rnd <= '0;
            state <= S_PRE;
          end else if (padding) state <= S_PAD;
          else state <= S_IDLE;
        end
        S_PRE: begin
          a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3]; e <= cv[4];
          state <= S_RND;
        end
        S_RND: begin
          win[4'(rnd)] <= w;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          cv[0] <= cv[0] + a; cv[1] <= cv[1] + b; cv[2] <= cv[2] + c;
          cv[3] <= cv[3] + d; cv[4] <= cv[4] + e;
          widx <= '0;
          if (padding && pad_len && len_idx == 4'd8) state <= S_OUT;
          else if (padding) state <= S_PAD;
          else state <= S_IDLE;
        end
        S_OUT: if (!out_stall) begin
          if (widx == 3'd4) begin
            widx <= '0;
            state <= S_IDLE;
            bit_length <= '0;
            pos <= '0;
            padding <= 1'b0;
            pad_mark <= 1'b0;
            pad_len <= 1'b0;
            for (int i = 0; i < 5; i++) cv[i] <= sha1_pkg::iv(3'(i));
          end else begin
            widx <= widx + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sha1_checker.sv @@
// Port checker for the SHA-1 message hasher.
`timescale 1ns / 1ps
module sha1_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sha1_pkg::out_item_t out_data
);
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.word_index <= 3'd4) else $error("bad word index");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd4)))
    else $error("last_word mismatch");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output changed");
endmodule

bind sha1_message_hasher sha1_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ test/sha1_hash_checker.sv @@
// Checker: watches both channels, predicts SHA-1 digests and compares them.
`timescale 1ns / 1ps
module sha1_hash_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sha1_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sha1_pkg::out_item_t out_data,
  output int                  err_count,
  output int                  pending_words,
  output int                  digests_seen
);

  logic [31:0] chain [5];
  logic [31:0] sched [16];
  logic [63:0] msg_bits;
  logic [5:0]  byte_pos;
  sha1_pkg::out_item_t digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) w = sched[r];
      else begin
        w = rol(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
                ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end
      if (r < 20) begin f = (b & c) | (~b & d); k = sha1_pkg::K0; end
      else if (r < 40) begin f = b ^ c ^ d; k = sha1_pkg::K1; end
      else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2; end
      else begin f = b ^ c ^ d; k = sha1_pkg::K3; end
      t = rol(a, 5) + f + e + k + w;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic absorb(input logic [7:0] v);
    int sh;
    sh = (3 - byte_pos[1:0]) * 8;
    if (byte_pos[1:0] == 0) sched[byte_pos[5:2]] = 32'(v) << sh;
    else sched[byte_pos[5:2]] |= 32'(v) << sh;
    byte_pos = byte_pos + 1;
    if (byte_pos == 0) hash_block();
  endtask

  task automatic clear_state();
    for (int i = 0; i < 5; i++) chain[i] = sha1_pkg::iv(3'(i));
    msg_bits = '0;
    byte_pos = '0;
  endtask

  task automatic predict(input sha1_pkg::in_item_t it);
    logic [63:0] len;
    sha1_pkg::out_item_t o;
    if (it.has_byte) begin
      absorb(it.msg_byte);
      msg_bits += 64'd8;
    end
    if (!it.last) return;
    len = msg_bits;
    absorb(sha1_pkg::PAD_BYTE);
    while (byte_pos != 6'd56) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(len[63 - 8 * i -: 8]);
    for (int i = 0; i < 5; i++) begin
      o.digest_word = chain[i];
      o.word_index = 3'(i);
      o.last_word = (i == 4);
      digest_q.push_back(o);
    end
    clear_state();
  endtask

  always @(posedge clk) begin
    sha1_pkg::out_item_t exp_w;
    if (rst) begin
      err_count <= 0;
      digests_seen <= 0;
      clear_state();
      digest_q.delete();
    end else begin
      if (in_valid && !in_stall) predict(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          if (err_count < 10) $display("unexpected digest word %h", out_data);
          err_count <= err_count + 1;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w !== out_data) begin
            if (err_count < 10)
              $display("digest mismatch: exp %h idx %0d lw %b, got %h idx %0d lw %b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
            err_count <= err_count + 1;
          end
          if (out_data.last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
    pending_words <= digest_q.size();
  end
endmodule

@@ test/tb_sha1_message_hasher.sv @@
// Testbench top: drives messages into the SHA-1 hasher and reports the verdict.
`timescale 1ns / 1ps
module tb_sha1_message_hasher;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  sha1_pkg::in_item_t in_data = '0;
  sha1_pkg::out_item_t out_data;
  int errors, pending, digests, cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  int items_sent = 0;

  always begin #1 clk = 1; #1 clk = 0; end

  sha1_message_hasher dut (.*);
  sha1_hash_checker chk (.clk, .rst, .in_valid, .in_stall, .in_data, .out_valid,
    .out_stall, .out_data, .err_count(errors), .pending_words(pending),
    .digests_seen(digests));

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_idle);

  // leaves valid high after the accepting edge; the caller drops it when done
  task automatic send(input logic [7:0] b, input bit hb, input bit lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_data <= '{msg_byte: b, has_byte: hb, last: lst};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_msg(input int n, input bit empty_last);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) send(8'($urandom), 0, 0);
      send(8'($urandom), 1, (i == n - 1) && !empty_last);
    end
    if (empty_last || n == 0) send(8'($urandom), 0, 1);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sizes [] = '{0, 1, 55, 56, 64};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(8'h00, 0, 1);
    send(8'hff, 0, 0);
    send(8'h00, 1, 0);
    send(8'hff, 1, 1);
    foreach (sizes[i]) send_msg(sizes[i], 1'(i % 2));
    in_valid <= 0;
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 22) : 0;
      recv_idle = (ph == 2) ? 79 : (ph == 3 ? 22 : 0);
      for (int m = 0; m < 4; m++)
        send_msg(($urandom_range(7) == 0) ? $urandom_range(70, 56)
                                          : $urandom_range(12, 0),
                 1'($urandom_range(1)));
      in_valid <= 0;
      drain();
    end
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_off <= 1;
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      begin
        for (int m = 0; m < 4; m++) send_msg(2, 0);
        in_valid <= 0;
      end
    join
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d items; %0d digests checked over empty, short and multi-block",
             items_sent, digests);
    $display("messages, with sender gaps, receiver stalls and a long hold-off.");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/sha1_pkg.sv
rtl/core/sha1_message_hasher.sv
rtl/core/sha1_checker.sv
test/sha1_hash_checker.sv
test/tb_sha1_message_hasher.sv
